/* src/wsa_pkg.sv */
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared widths and scale constants for the windowed slope acceleration block.
// ----------------------------------------------------------------------------
package wsa_pkg;

  localparam int HALF_WINDOW_DEF = 5;

  localparam int DIST_W  = 24;
  localparam int SPD_W   = 16;
  localparam int ACCEL_W = 16;
  localparam int INDEX_W = 16;

  // accel = speed * slope * 125 / 162
  localparam int SPD_SCALE = 125;
  localparam int DEN_SCALE = 162;
  localparam int MULT_W    = 23;   // holds 65535 * 125
  localparam int QBITS     = 17;   // quotient bits below the overflow bit

endpackage

/* src/wsa_if.sv */
// ----------------------------------------------------------------------------
// wsa_in_if / wsa_out_if
// Valid/ready channels for samples and acceleration results.
// ----------------------------------------------------------------------------
interface wsa_in_if;
  import wsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_cm;
  logic [SPD_W-1:0]  speed_centi_kmh;
  logic              is_last;

  modport source (output valid, distance_cm, speed_centi_kmh, is_last, input ready);
  modport sink   (input valid, distance_cm, speed_centi_kmh, is_last, output ready);
endinterface

interface wsa_out_if;
  import wsa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_milli;
  logic [INDEX_W-1:0]        sample_index;
  logic                      last_out;

  modport source (output valid, accel_milli, sample_index, last_out, input ready);
  modport sink   (input valid, accel_milli, sample_index, last_out, output ready);
endinterface

/* src/windowed_slope_accel.sv */
// ----------------------------------------------------------------------------
// windowed_slope_accel
// Sliding-window least-squares slope of speed over distance, scaled to an
// acceleration in mm/s^2.
// ----------------------------------------------------------------------------
// Each sample shifts into a window of 2*HALF_WINDOW+1 entries. Once
// HALF_WINDOW+1 samples are in, every sample yields the result for the sample
// HALF_WINDOW positions back; a beat with is_last set yields all pending
// results and starts a new stream at index 0. Results are computed one at a
// time by a sequencer: it walks the entries of the clipped window (at most
// 2*HALF_WINDOW+1) through one multiply-accumulate stage, forms the sums'
// cross terms, and then a shared serial unit forms the speed product and
// the division. Input is taken only while no result is being computed; a
// finished result sits in the output register and does not hold up the
// next sample.
module windowed_slope_accel
  import wsa_pkg::*;
#(
  parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  wsa_in_if.sink    in_ch,
  wsa_out_if.source out_ch
);

  localparam int WDEPTH = 2 * HALF_WINDOW + 1;
  localparam int IW     = $clog2(WDEPTH);
  localparam int NW     = $clog2(WDEPTH + 1);
  localparam int XW     = DIST_W + 1;
  localparam int SXW    = XW + NW;
  localparam int SYW    = SPD_W + NW;
  localparam int SXXW   = 2 * DIST_W + NW;
  localparam int PXYW   = XW + SPD_W + 1;
  localparam int SXYW   = PXYW + NW;
  localparam int NSXXW  = SXXW + NW;
  localparam int SXSXW  = 2 * SXW;
  localparam int NSXYW  = SXYW + NW + 1;
  localparam int SXSYW  = SXW + SYW + 1;
  localparam int DENW   = 2 * SXW + 2;
  localparam int NUMW   = NSXYW + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_X0    = 4'd1;
  localparam logic [3:0] S_SPD   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_DRN   = 4'd4;
  localparam logic [3:0] S_PROD  = 4'd5;
  localparam logic [3:0] S_DIFF  = 4'd6;
  localparam logic [3:0] S_SETUP = 4'd7;
  localparam logic [3:0] S_WAIT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [DIST_W-1:0] dwin_r [WDEPTH];
  logic [SPD_W-1:0]  swin_r [WDEPTH];

  logic [3:0]         st_r, st_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic [INDEX_W-1:0] nidx_r, nidx_nxt;
  logic [IW-1:0]      p_r, p_nxt;
  logic               flush_r, flush_nxt;
  logic [IW-1:0]      ai_r, ai_nxt;

  logic [DIST_W-1:0] x0_r;
  logic [SPD_W-1:0]  spd_r;
  logic              pv_r;
  logic [2*DIST_W-1:0]      pxx_r;
  logic signed [PXYW-1:0]   pxy_r;
  logic signed [XW-1:0]     px_r;
  logic [SPD_W-1:0]         py_r;
  logic signed [SXW-1:0]    sx_r;
  logic [SYW-1:0]           sy_r;
  logic [SXXW-1:0]          sxx_r;
  logic signed [SXYW-1:0]   sxy_r;
  logic [NSXXW-1:0]         nsxx_r;
  logic signed [SXSXW-1:0]  sxsx_r;
  logic signed [NSXYW-1:0]  nsxy_r;
  logic signed [SXSYW-1:0]  sxsy_r;
  logic signed [DENW-1:0]   den_r;
  logic signed [NUMW-1:0]   num_r;
  logic [QBITS:0]           q_r;
  logic                     neg_r;

  logic                      out_valid_r;
  logic signed [ACCEL_W-1:0] out_accel_r;
  logic [INDEX_W-1:0]        out_idx_r;
  logic                      out_last_r;

  logic                   acc_in;
  logic [NW-1:0]          cnt_inc;
  logic [NW-1:0]          pend_w;
  logic [IW-1:0]          first_w, lo_w, rd_idx;
  logic [NW-1:0]          n_w;
  logic [DIST_W-1:0]      rd_d;
  logic [SPD_W-1:0]       rd_s;
  logic signed [XW-1:0]   x_w;
  logic signed [2*XW-1:0] sq_w;
  logic signed [PXYW-1:0] xy_w;
  logic                   job_end;
  logic                   out_load;
  logic                   zero_res;
  logic                   div_start, div_done;
  logic [QBITS:0]         div_q;
  logic [NUMW-1:0]        mag_w;
  logic signed [ACCEL_W-1:0] accel_w;

  assign in_ch.ready = (st_r == S_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign cnt_inc     = (cnt_r < NW'(WDEPTH)) ? cnt_r + 1'b1 : cnt_r;
  assign pend_w      = (cnt_inc < NW'(HALF_WINDOW + 1)) ? cnt_inc : NW'(HALF_WINDOW + 1);

  // window clipped at the stream start
  assign first_w = IW'(NW'(WDEPTH) - cnt_r);
  assign lo_w    = (p_r - IW'(HALF_WINDOW) < first_w) ? first_w : p_r - IW'(HALF_WINDOW);
  assign n_w     = NW'(WDEPTH) - NW'(lo_w);

  always_comb begin
    case (st_r)
      S_X0:    rd_idx = lo_w;
      S_SPD:   rd_idx = p_r;
      default: rd_idx = ai_r;
    endcase
  end

  assign rd_d = dwin_r[rd_idx];
  assign rd_s = swin_r[rd_idx];
  assign x_w  = $signed({1'b0, rd_d}) - $signed({1'b0, x0_r});
  assign sq_w = x_w * x_w;
  assign xy_w = x_w * $signed({1'b0, rd_s});

  assign job_end  = flush_r ? (p_r == IW'(WDEPTH - 1)) : 1'b1;
  assign out_load = (st_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign zero_res = (n_w < NW'(2)) || den_r[DENW-1] || (den_r == '0) ||
                    (num_r == '0) || (spd_r == '0);
  assign mag_w    = num_r[NUMW-1] ? NUMW'(-num_r) : NUMW'(num_r);
  assign div_start = (st_r == S_SETUP) && !zero_res;

  wsa_divider #(
    .MAGW (NUMW),
    .DENW (DENW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .mag_i   (mag_w),
    .mult_i  (MULT_W'(spd_r) * MULT_W'(SPD_SCALE)),
    .den_i   (den_r[DENW-2:0]),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    if (!neg_r) begin
      accel_w = (q_r > (QBITS+1)'(32767)) ? ACCEL_W'(32767) : $signed(q_r[ACCEL_W-1:0]);
    end else begin
      accel_w = (q_r > (QBITS+1)'(32768)) ? $signed({1'b1, {(ACCEL_W-1){1'b0}}})
                                          : $signed(ACCEL_W'(-q_r));
    end
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    nidx_nxt  = nidx_r;
    p_nxt     = p_r;
    flush_nxt = flush_r;
    ai_nxt    = ai_r;
    case (st_r)
      S_IDLE: begin
        if (acc_in) begin
          cnt_nxt = cnt_inc;
          if (in_ch.is_last) begin
            flush_nxt = 1'b1;
            p_nxt     = IW'(NW'(WDEPTH) - pend_w);
            st_nxt    = S_X0;
          end else if (cnt_inc >= NW'(HALF_WINDOW + 1)) begin
            flush_nxt = 1'b0;
            p_nxt     = IW'(HALF_WINDOW);
            st_nxt    = S_X0;
          end
        end
      end
      S_X0: begin
        ai_nxt = lo_w;
        st_nxt = S_SPD;
      end
      S_SPD: st_nxt = S_ACC;
      S_ACC: begin
        ai_nxt = ai_r + 1'b1;
        if (ai_r == IW'(WDEPTH - 1)) st_nxt = S_DRN;
      end
      S_DRN:   st_nxt = S_PROD;
      S_PROD:  st_nxt = S_DIFF;
      S_DIFF:  st_nxt = S_SETUP;
      S_SETUP: st_nxt = zero_res ? S_DONE : S_WAIT;
      S_WAIT: begin
        if (div_done) st_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          nidx_nxt = nidx_r + 1'b1;
          if (job_end) begin
            st_nxt = S_IDLE;
            if (flush_r) begin
              cnt_nxt  = '0;
              nidx_nxt = '0;
            end
          end else begin
            p_nxt  = p_r + 1'b1;
            st_nxt = S_X0;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      nidx_r      <= '0;
      flush_r     <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      nidx_r  <= nidx_nxt;
      flush_r <= flush_nxt;
      pv_r    <= (st_r == S_ACC);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // window shift, newest at the top
  always_ff @(posedge clk) begin
    if (acc_in) begin
      for (int k = 0; k < WDEPTH - 1; k++) begin
        dwin_r[k] <= dwin_r[k+1];
        swin_r[k] <= swin_r[k+1];
      end
      dwin_r[WDEPTH-1] <= in_ch.distance_cm;
      swin_r[WDEPTH-1] <= in_ch.speed_centi_kmh;
    end
  end

  always_ff @(posedge clk) begin
    p_r  <= p_nxt;
    ai_r <= ai_nxt;
    if (st_r == S_X0) x0_r <= rd_d;
    if (st_r == S_SPD) spd_r <= rd_s;

    pxx_r <= sq_w[2*DIST_W-1:0];
    pxy_r <= xy_w;
    px_r  <= x_w;
    py_r  <= rd_s;

    if (st_r == S_X0) begin
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      sxy_r <= '0;
    end else if (pv_r) begin
      sx_r  <= sx_r + SXW'(px_r);
      sy_r  <= sy_r + SYW'(py_r);
      sxx_r <= sxx_r + SXXW'(pxx_r);
      sxy_r <= sxy_r + SXYW'(pxy_r);
    end

    if (st_r == S_PROD) begin
      nsxx_r <= NSXXW'(sxx_r) * NSXXW'(n_w);
      sxsx_r <= SXSXW'(sx_r) * SXSXW'(sx_r);
      nsxy_r <= NSXYW'(sxy_r) * NSXYW'($signed({1'b0, n_w}));
      sxsy_r <= SXSYW'(sx_r) * SXSYW'($signed({1'b0, sy_r}));
    end
    if (st_r == S_DIFF) begin
      den_r <= DENW'($signed({1'b0, nsxx_r})) - DENW'(sxsx_r);
      num_r <= NUMW'(nsxy_r) - NUMW'(sxsy_r);
    end
    if (st_r == S_SETUP) begin
      neg_r <= num_r[NUMW-1];
      q_r   <= '0;
    end else if (st_r == S_WAIT && div_done) begin
      q_r <= div_q;
    end

    if (out_load) begin
      out_accel_r <= accel_w;
      out_idx_r   <= nidx_r;
      out_last_r  <= flush_r && (p_r == IW'(WDEPTH - 1));
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accel_milli  = out_accel_r;
  assign out_ch.sample_index = out_idx_r;
  assign out_ch.last_out     = out_last_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == S_WAIT)
    else $error("divider finished outside its wait state");

  a_flush_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && flush_r && job_end |=> cnt_r == '0 && nidx_r == '0)
    else $error("stream state not cleared after the final result");

  a_mac_follows_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(st_r) == S_ACC)
    else $error("accumulate beat without a window walk");

endmodule

/* src/wsa_divider.sv */
// ----------------------------------------------------------------------------
// wsa_divider
// Bit-serial product mag * mult, then restoring division by den * 162,
// one bit per cycle. Quotient saturates at 2^17.
// ----------------------------------------------------------------------------
module wsa_divider
  import wsa_pkg::*;
#(
  parameter int MAGW = 52,
  parameter int DENW = 59
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  logic [MAGW-1:0]   mag_i,
  input  logic [MULT_W-1:0] mult_i,
  input  logic [DENW-2:0]   den_i,
  output logic              done_o,
  output logic [QBITS:0]    q_o
);

  localparam int QW = DENW + 26;
  localparam int CW = $clog2(MULT_W + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_OVF  = 2'd2;
  localparam logic [1:0] D_DIV  = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [QW-1:0]     pr_r, pr_nxt;
  logic [QW-1:0]     dsh_r, dsh_nxt;
  logic [MAGW-1:0]   mag_r, mag_nxt;
  logic [MULT_W-1:0] m_r, m_nxt;
  logic [QBITS:0]    q_r, q_nxt;
  logic              done_r, done_nxt;
  logic              ge_w;

  assign ge_w = (pr_r >= dsh_r);

  always_comb begin
    st_nxt   = st_r;
    k_nxt    = k_r;
    pr_nxt   = pr_r;
    dsh_nxt  = dsh_r;
    mag_nxt  = mag_r;
    m_nxt    = m_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    case (st_r)
      D_IDLE: begin
        if (start_i) begin
          pr_nxt  = '0;
          mag_nxt = mag_i;
          m_nxt   = mult_i;
          dsh_nxt = (QW'(den_i) * QW'(DEN_SCALE)) << QBITS;
          k_nxt   = CW'(MULT_W);
          q_nxt   = '0;
          st_nxt  = D_MUL;
        end
      end
      D_MUL: begin
        pr_nxt = (pr_r << 1) + (m_r[MULT_W-1] ? QW'(mag_r) : '0);
        m_nxt  = m_r << 1;
        k_nxt  = k_r - 1'b1;
        if (k_r == CW'(1)) st_nxt = D_OVF;
      end
      D_OVF: begin
        if (ge_w) begin
          q_nxt    = {1'b1, {QBITS{1'b0}}};
          done_nxt = 1'b1;
          st_nxt   = D_IDLE;
        end else begin
          dsh_nxt = dsh_r >> 1;
          k_nxt   = CW'(QBITS);
          st_nxt  = D_DIV;
        end
      end
      D_DIV: begin
        if (ge_w) pr_nxt = pr_r - dsh_r;
        q_nxt   = {q_r[QBITS-1:0], ge_w};
        dsh_nxt = dsh_r >> 1;
        k_nxt   = k_r - 1'b1;
        if (k_r == CW'(1)) begin
          done_nxt = 1'b1;
          st_nxt   = D_IDLE;
        end
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    k_r   <= k_nxt;
    pr_r  <= pr_nxt;
    dsh_r <= dsh_nxt;
    mag_r <= mag_nxt;
    m_r   <= m_nxt;
    q_r   <= q_nxt;
  end

  assign done_o = done_r;
  assign q_o    = q_r;

endmodule

/* tb/tb_windowed_slope_accel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_slope_accel
// Streams of (distance, speed) samples go into the block. An in-bench
// least-squares slope predictor works out the acceleration beats that each
// sample should release. Every result beat is compared in order against that
// list. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_windowed_slope_accel;
  import wsa_pkg::*;

  localparam int HW         = HALF_WINDOW_DEF;
  localparam int DEPTH      = 2 * HW + 1;
  localparam int N_RANDOM   = 290;
  localparam int CYCLE_CAP  = 1000000;

  typedef struct {
    logic signed [ACCEL_W-1:0] accel;
    logic [INDEX_W-1:0]        idx;
    logic                      last;
  } accel_beat_t;

  typedef struct {
    logic [DIST_W-1:0] dist_cm;
    logic [SPD_W-1:0]  spd;
    logic              last;
    bit                typed;    // accel of the final beat is known by hand
    int                accel;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wsa_in_if  in_ch ();
  wsa_out_if out_ch ();

  windowed_slope_accel DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [DIST_W-1:0]  dist_win [DEPTH];
  logic [SPD_W-1:0]   spd_win  [DEPTH];
  int unsigned        seen_cnt;
  logic [INDEX_W-1:0] next_idx;

  accel_beat_t pending_accels[$];
  int          err_count = 0;
  int unsigned cycle_cnt = 0;
  bit          quiet = 1'b0;

  sample_row_t directed_rows[] = '{
    // lone sample: too few entries for a fit
    '{24'd100, 16'd500, 1'b1, 1'b1, 0},
    // flat distances: zero denominator
    '{24'd1000, 16'd1000, 1'b0, 1'b0, 0},
    '{24'd1000, 16'd2000, 1'b0, 1'b0, 0},
    '{24'd1000, 16'd3000, 1'b1, 1'b1, 0},
    // steep rise: saturate high
    '{24'd0, 16'd0, 1'b0, 1'b0, 0},
    '{24'd1, 16'hFFFF, 1'b0, 1'b0, 0},
    '{24'd2, 16'hFFFF, 1'b1, 1'b0, 0},
    // steep fall: saturate low
    '{24'd0, 16'hFFFF, 1'b0, 1'b0, 0},
    '{24'd1, 16'd0, 1'b1, 1'b0, 0},
    // field extremes across a full window and beyond
    '{24'd0, 16'hFFFF, 1'b0, 1'b0, 0},
    '{24'hFFFFFF, 16'd0, 1'b0, 1'b0, 0},
    '{24'd1, 16'hFFFF, 1'b0, 1'b0, 0},
    '{24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0, 0},
    '{24'd0, 16'd0, 1'b0, 1'b0, 0},
    '{24'hAAAAAA, 16'h5555, 1'b0, 1'b0, 0},
    '{24'h555555, 16'hAAAA, 1'b0, 1'b0, 0},
    '{24'd2, 16'd1, 1'b0, 1'b0, 0},
    '{24'd3, 16'hFFFF, 1'b0, 1'b0, 0},
    '{24'h800000, 16'h8000, 1'b0, 1'b0, 0},
    '{24'h7FFFFF, 16'h7FFF, 1'b0, 1'b0, 0},
    '{24'd40, 16'd100, 1'b0, 1'b0, 0},
    '{24'd80, 16'd120, 1'b0, 1'b0, 0},
    '{24'hFFFFFF, 16'hFFFF, 1'b1, 1'b0, 0}
  };

  function automatic int slope_accel(int p, int lo, int hi);
    longint n, sx, sy, sxx, sxy, x, y, x0, den, num, mag;
    logic [127:0] prod, div, quo;
    if (hi - lo < 1) return 0;
    n = hi - lo + 1;
    sx = 0; sy = 0; sxx = 0; sxy = 0;
    x0 = longint'(dist_win[lo]);
    for (int i = lo; i <= hi; i++) begin
      x = longint'(dist_win[i]) - x0;
      y = longint'(spd_win[i]);
      sx += x; sy += y; sxx += x * x; sxy += x * y;
    end
    den = n * sxx - sx * sx;
    if (den <= 0) return 0;
    num = n * sxy - sx * sy;
    if (num == 0 || spd_win[p] == '0) return 0;
    mag = (num < 0) ? -num : num;
    prod = 128'(mag) * 128'(spd_win[p]) * 128'(SPD_SCALE);
    div  = 128'(den) * 128'(DEN_SCALE);
    quo  = prod / div;
    if (quo > 128'(1 << QBITS)) quo = 128'(1 << QBITS);
    if (num > 0) return (quo > 128'd32767) ? 32767 : int'(quo);
    return (quo > 128'd32768) ? -32768 : -int'(quo);
  endfunction

  function automatic void clear_stream();
    for (int i = 0; i < DEPTH; i++) begin
      dist_win[i] = '0;
      spd_win[i]  = '0;
    end
    seen_cnt = 0;
    next_idx = '0;
  endfunction

  // Shift one sample in and queue the beats it releases.
  function automatic void predict_sample(logic [DIST_W-1:0] d, logic [SPD_W-1:0] s,
                                         logic last);
    int first, npend, p, lo;
    accel_beat_t b;
    for (int i = 0; i < DEPTH - 1; i++) begin
      dist_win[i] = dist_win[i + 1];
      spd_win[i]  = spd_win[i + 1];
    end
    dist_win[DEPTH-1] = d;
    spd_win[DEPTH-1]  = s;
    if (seen_cnt < 65535) seen_cnt++;
    first = DEPTH - ((seen_cnt < DEPTH) ? seen_cnt : DEPTH);
    npend = (seen_cnt < HW + 1) ? seen_cnt : HW + 1;
    if (!last && npend < HW + 1) return;
    if (!last) npend = 1;
    for (int i = 0; i < npend; i++) begin
      p  = last ? DEPTH - npend + i : HW;
      lo = (p - HW < first) ? first : p - HW;
      b.accel = ACCEL_W'(slope_accel(p, lo, DEPTH - 1));
      b.idx   = next_idx;
      b.last  = last && (i == npend - 1);
      pending_accels = {pending_accels, b};
      next_idx++;
    end
    if (last) clear_stream();
  endfunction

  task automatic send_sample(sample_row_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.distance_cm     <= r.dist_cm;
    in_ch.speed_centi_kmh <= r.spd;
    in_ch.is_last         <= r.last;
    do @(posedge clk); while (!in_ch.ready);
    predict_sample(r.dist_cm, r.spd, r.last);
    if (r.typed) pending_accels[pending_accels.size() - 1].accel = ACCEL_W'(r.accel);
  endtask

  // result side: random stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(1, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    accel_beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_accels.size() == 0) begin
        $error("unexpected result beat: accel_milli %0d sample_index %0d",
               out_ch.accel_milli, out_ch.sample_index);
        err_count++;
      end else begin
        e = pending_accels.pop_front();
        if (out_ch.accel_milli !== e.accel) begin
          $error("accel_milli: expected %0d, got %0d", e.accel, out_ch.accel_milli);
          err_count++;
        end
        if (out_ch.sample_index !== e.idx) begin
          $error("sample_index: expected %0d, got %0d", e.idx, out_ch.sample_index);
          err_count++;
        end
        if (out_ch.last_out !== e.last) begin
          $error("last_out: expected %0d, got %0d", e.last, out_ch.last_out);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    sample_row_t r;
    int          run_len, step_kind;
    logic [DIST_W-1:0] pos;
    in_ch.valid           = 1'b0;
    in_ch.distance_cm     = '0;
    in_ch.speed_centi_kmh = '0;
    in_ch.is_last         = 1'b0;
    clear_stream();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_sample(directed_rows[i]);

    // random streams: mostly rising distances, some noise and flat runs
    run_len = 0;
    pos = '0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k > N_RANDOM - 40) quiet = 1'b1;
      if (run_len == 0) begin
        run_len   = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : $urandom_range(7, 30);
        pos       = $urandom;
        step_kind = $urandom_range(0, 9);
      end
      case (step_kind)
        0:       pos = $urandom;                         // noise
        1:       pos = pos;                              // flat
        2:       pos = pos - DIST_W'($urandom_range(0, 3000));
        default: pos = pos + DIST_W'($urandom_range(0, 3000));
      endcase
      r.dist_cm = pos;
      r.spd   = ($urandom_range(0, 7) == 0) ? SPD_W'($urandom) : SPD_W'($urandom_range(0, 30000));
      run_len--;
      r.last  = (run_len == 0) || (k == N_RANDOM - 1);
      if (r.last) run_len = 0;
      r.typed = 1'b0;
      r.accel = 0;
      send_sample(r);
    end
    in_ch.valid <= 1'b0;

    while (pending_accels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
